@@ rtl/core/cdd_pkg.sv @@
// Shared constants and types for the cable detect debounce block.
package cdd_pkg;

  localparam int CHANNELS      = 4;
  localparam int SAMPLE_BITS   = 12;
  localparam int LEVEL_BITS    = 12;
  localparam int COUNT_BITS    = 8;
  localparam int CABLE_BITS    = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int IN_DATA_BITS  = CHANNELS * SAMPLE_BITS;
  localparam int OUT_DATA_BITS = 8;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DETECT_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CABLE_COUNT   = 2'd2;

  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET   = 12'd2048;
  localparam logic [COUNT_BITS-1:0] CONFIRM_RESET = 8'd10;
  localparam logic [CABLE_BITS-1:0] CABLE_RESET   = 3'd0;

  // scan kinds
  localparam logic KIND_PROCESS = 1'b0;
  localparam logic KIND_SERVICE = 1'b1;

  // run counter limits
  localparam logic [COUNT_BITS-1:0] HIT_FOLD_AT = 8'd254;
  localparam logic [COUNT_BITS-1:0] HIT_FOLD_TO = 8'd50;
  localparam logic [COUNT_BITS-1:0] RUN_WRAP    = 8'd200;

  typedef struct packed {
    logic [COUNT_BITS-1:0] hit_run;
    logic [COUNT_BITS-1:0] release_run;
    logic                  latched;
    logic                  trig;
  } lane_state_t;

  typedef struct packed {
    lane_state_t nxt;   // candidate next state
    logic        hold;  // service scan: channel ends latched
  } lane_res_t;

endpackage

@@ rtl/core/cable_detect_debounce.sv @@
// Top level: four-channel threshold debounce filter for cable detection.
// The result of an accepted request is registered and appears on out_tdata in the next cycle.
// Throughput: one request per cycle unless a held result stalls; all four lanes and the merge are combinational.
// in_tready drops only while a result waits and out_tready is low.
// Reset (rst_n low, synchronous): counters, latches, flags cleared, output empty,
// registers back to level 2048, confirm 10, no cables.
module cable_detect_debounce
  import cdd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // scan requests
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // sample_0, sample_1, sample_2, sample_3
  input  logic                     in_tuser,   // kind
  // results
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // triggered_mask[3:0], detected, zero pad
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [LEVEL_BITS-1:0] level_r;
  logic [COUNT_BITS-1:0] confirm_r;
  logic [CABLE_BITS-1:0] cables_r;

  lane_state_t [CHANNELS-1:0] state_r;
  lane_state_t [CHANNELS-1:0] state_nxt;
  lane_res_t   [CHANNELS-1:0] res;

  logic [CHANNELS-1:0]      enable;
  logic [CHANNELS-1:0]      commit;
  logic [CHANNELS-1:0]      mask;
  logic                     detected;
  logic                     accept;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  // Register writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LEVEL_RESET;
      confirm_r <= CONFIRM_RESET;
      cables_r  <= CABLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DETECT_LEVEL:  level_r   <= cfg_data[LEVEL_BITS-1:0];
        CFG_CONFIRM_COUNT: confirm_r <= cfg_data[COUNT_BITS-1:0];
        CFG_CABLE_COUNT:   cables_r  <= cfg_data[CABLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Cables enable channels in the order 3, 1, 2, 0; four or more means all.
  assign enable[3] = cables_r >= CABLE_BITS'(1);
  assign enable[1] = cables_r >= CABLE_BITS'(2);
  assign enable[2] = cables_r >= CABLE_BITS'(3);
  assign enable[0] = cables_r >= CABLE_BITS'(4);

  // One lane per channel, all working on the same scan.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    cdd_lane u_lane (
      .kind    (in_tuser),
      .enable  (enable[g]),
      .sample  (in_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .level   (level_r),
      .confirm (confirm_r),
      .cur     (state_r[g]),
      .res     (res[g])
    );
  end

  // Service scans stop at the first channel left latched; later lanes keep state.
  cdd_merge u_merge (
    .kind           (in_tuser),
    .res            (res),
    .commit         (commit),
    .triggered_mask (mask),
    .detected       (detected)
  );

  // Output register: a new scan goes in as soon as the held result leaves.
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      state_nxt[i] = (accept && commit[i]) ? res[i].nxt : state_r[i];
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {{(OUT_DATA_BITS-CHANNELS-1){1'b0}}, detected, mask};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/core/cdd_lane.sv @@
// One channel of the debounce filter: run counters, trigger and latch update.
module cdd_lane
  import cdd_pkg::*;
(
  input  logic                   kind,
  input  logic                   enable,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [LEVEL_BITS-1:0]  level,
  input  logic [COUNT_BITS-1:0]  confirm,
  input  lane_state_t            cur,
  output lane_res_t              res
);

  logic                  hit;
  logic                  low;
  logic [COUNT_BITS-1:0] h1;
  logic [COUNT_BITS-1:0] hs;
  logic [COUNT_BITS-1:0] r1;
  logic [COUNT_BITS-1:0] rs;
  logic                  lat;

  assign hit = sample >= level;
  assign low = sample <= level;
  assign h1  = hit ? cur.hit_run + COUNT_BITS'(1) : '0;

  // service path
  assign hs  = (h1 == RUN_WRAP) ? '0 : h1;
  assign lat = cur.latched | (hs >= confirm);
  assign r1  = (lat && low) ? cur.release_run + COUNT_BITS'(1) : '0;
  assign rs  = (r1 == RUN_WRAP) ? '0 : r1;

  always_comb begin
    res.nxt  = cur;
    res.hold = 1'b0;
    if (enable) begin
      if (kind == KIND_PROCESS) begin
        res.nxt.trig    = h1 >= confirm;
        res.nxt.hit_run = (h1 >= HIT_FOLD_AT) ? HIT_FOLD_TO : h1;
      end else begin
        res.nxt.hit_run     = hs;
        res.nxt.release_run = rs;
        res.nxt.latched     = lat & ~(rs >= confirm);
        res.hold            = lat & ~(rs >= confirm);
      end
    end
  end

endmodule

@@ rtl/core/cdd_merge.sv @@
// Combines lane results: early stop in service scans and the result fields.
module cdd_merge
  import cdd_pkg::*;
(
  input  logic                           kind,
  input  lane_res_t [CHANNELS-1:0]       res,
  output logic      [CHANNELS-1:0]       commit,
  output logic      [CHANNELS-1:0]       triggered_mask,
  output logic                           detected
);

  logic stop;

  always_comb begin
    stop = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      commit[i]         = (kind == KIND_PROCESS) | ~stop;
      stop              = stop | res[i].hold;
      triggered_mask[i] = (kind == KIND_PROCESS) & res[i].nxt.trig;
    end
    detected = (kind == KIND_SERVICE) & stop;
  end

endmodule

@@ rtl/core/cdd_checker.sv @@
// Port-level checks for cable_detect_debounce, bound to the top level.
module cdd_checker
  import cdd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted request shows a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request gave no result");

  // process and service results never mix
  a_field_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CHANNELS] |-> out_tdata[CHANNELS-1:0] == '0)
    else $error("detected set together with triggered flags");

  // output is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result present after reset");

endmodule

bind cable_detect_debounce cdd_checker u_cdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
